/* sv/slt_pkg.sv */
// ----------------------------------------------------------------------------
// slt_pkg: shared types and codes of the station learning table
// Result status codes, result record and the link record passed from cell
// to cell along the entry row.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int MAC_W     = 48;
    localparam int RSSI_W    = 8;
    localparam int TIME_W    = 32;
    localparam int CHAN_W    = 4;
    localparam int COUNT_W32 = 32;
    localparam int TAG_W     = 6;

    localparam logic [CHAN_W-1:0] CHANNEL_RESET = 4'd1;

    typedef enum logic [1:0] {
        STATUS_UPDATED  = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_DROPPED  = 2'd2
    } status_t;

    typedef struct packed {
        status_t                status;
        logic [TAG_W-1:0]       entry_index;
        logic [COUNT_W32-1:0]   packet_total;
        logic [TIME_W-1:0]      first_seen_ms;
    } result_t;

    // request walking the row; done marks that some cell matched or inserted
    typedef struct packed {
        logic                   valid;
        logic                   done;
        logic [MAC_W-1:0]       station_address;
        logic signed [RSSI_W-1:0] signal_strength;
        logic [TIME_W-1:0]      now_ms;
        result_t                res;
    } link_t;

endpackage

/* sv/slt_if.sv */
// ----------------------------------------------------------------------------
// slt_if: request and result channels of the station learning table
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface slt_frame_if;
    logic                     valid;
    logic                     ready;
    logic [47:0]              station_address;
    logic signed [7:0]        signal_strength;
    logic [31:0]              now_ms;

    modport source (
        output valid, station_address, signal_strength, now_ms,
        input  ready
    );
    modport sink (
        input  valid, station_address, signal_strength, now_ms,
        output ready
    );
endinterface

interface slt_result_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [5:0]               entry_index;
    logic [31:0]              packet_total;
    logic [31:0]              first_seen_ms;

    modport source (
        output valid, status, entry_index, packet_total, first_seen_ms,
        input  ready
    );
    modport sink (
        input  valid, status, entry_index, packet_total, first_seen_ms,
        output ready
    );
endinterface

/* sv/slt_cell.sv */
// ----------------------------------------------------------------------------
// slt_cell: one station entry of the learning row
// Holds one entry, compares the passing request against it, updates or
// fills the entry and hands the request on to the next cell through its link register.
// ----------------------------------------------------------------------------
module slt_cell #(
    parameter int INDEX   = 0,
    parameter int COUNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [slt_pkg::CHAN_W-1:0]    channel,
    input  logic [COUNT_W-1:0]            used_count,
    input  slt_pkg::link_t                link_in,
    output slt_pkg::link_t                link_out
);

    localparam logic [COUNT_W-1:0]           POS = COUNT_W'(INDEX);
    localparam logic [slt_pkg::TAG_W-1:0]    TAG = slt_pkg::TAG_W'(INDEX % 64);

    logic [slt_pkg::MAC_W-1:0]       mac_reg,        mac_next;
    logic signed [slt_pkg::RSSI_W-1:0] rssi_reg,     rssi_next;
    logic [slt_pkg::CHAN_W-1:0]      channel_reg,    channel_next;
    logic [slt_pkg::TIME_W-1:0]      last_seen_reg,  last_seen_next;
    logic [slt_pkg::TIME_W-1:0]      first_seen_reg, first_seen_next;
    logic [slt_pkg::COUNT_W32-1:0]   packets_reg,    packets_next;
    slt_pkg::link_t                  link_reg,       link_next;

    logic                            live;
    logic                            hit;
    logic                            fill;
    logic [slt_pkg::COUNT_W32-1:0]   packets_inc;

    assign live = link_in.valid && !link_in.done;
    assign hit  = live && (POS < used_count) && (mac_reg == link_in.station_address);
    // first free slot takes a request that matched nowhere before it
    assign fill = live && (used_count == POS);

    assign packets_inc = (packets_reg == '1) ? packets_reg
                                             : packets_reg + slt_pkg::COUNT_W32'(1);

    always_comb
    begin
        mac_next        = mac_reg;
        rssi_next       = rssi_reg;
        channel_next    = channel_reg;
        last_seen_next  = last_seen_reg;
        first_seen_next = first_seen_reg;
        packets_next    = packets_reg;
        link_next       = link_in;
        if (hit)
        begin
            rssi_next                   = link_in.signal_strength;
            channel_next                = channel;
            last_seen_next              = link_in.now_ms;
            packets_next                = packets_inc;
            link_next.done              = 1'b1;
            link_next.res.status        = slt_pkg::STATUS_UPDATED;
            link_next.res.entry_index   = TAG;
            link_next.res.packet_total  = packets_inc;
            link_next.res.first_seen_ms = first_seen_reg;
        end
        else if (fill)
        begin
            mac_next                    = link_in.station_address;
            rssi_next                   = link_in.signal_strength;
            channel_next                = channel;
            last_seen_next              = link_in.now_ms;
            first_seen_next             = link_in.now_ms;
            packets_next                = slt_pkg::COUNT_W32'(1);
            link_next.done              = 1'b1;
            link_next.res.status        = slt_pkg::STATUS_INSERTED;
            link_next.res.entry_index   = TAG;
            link_next.res.packet_total  = slt_pkg::COUNT_W32'(1);
            link_next.res.first_seen_ms = link_in.now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg        <= mac_next;
        rssi_reg       <= rssi_next;
        channel_reg    <= channel_next;
        last_seen_reg  <= last_seen_next;
        first_seen_reg <= first_seen_next;
        packets_reg    <= packets_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

/* sv/station_learning_table.sv */
// Each request walks the row of entry cells one cell per cycle before the
// next one is accepted; a new request also waits while the skid stage is full.
// A finished result waits in an output register with a skid stage behind it.
// Reset empties the table (fill count 0) and sets the channel to 1.
// ----------------------------------------------------------------------------
// station_learning_table: MAC address learning table of radio stations
// Matches each request's address against the stored stations, updates the
// matching entry, appends one or drops when full, and reports one status per request.
// ----------------------------------------------------------------------------
module station_learning_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [3:0]                 cfg_data,
    slt_frame_if.sink                  frame,
    slt_result_if.source               result
);

    localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(TABLE_DEPTH);

    logic                              busy_reg,       busy_next;
    logic [COUNT_W-1:0]                used_reg,       used_next;
    logic [slt_pkg::CHAN_W-1:0]        channel_reg,    channel_next;
    slt_pkg::link_t                    launch_reg,     launch_next;
    logic                              out_valid_reg,  out_valid_next;
    slt_pkg::result_t                  out_reg,        out_next;
    logic                              skid_valid_reg, skid_valid_next;
    slt_pkg::result_t                  skid_reg,       skid_next;

    slt_pkg::link_t                    links [TABLE_DEPTH+1];
    slt_pkg::link_t                    tail;
    slt_pkg::result_t                  tail_res;
    logic                              accept;
    logic                              out_take;

    assign frame.ready = !busy_reg && !skid_valid_reg;
    assign accept      = frame.valid && frame.ready;
    assign out_take    = out_valid_reg && result.ready;

    assign links[0] = launch_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        slt_cell #(
            .INDEX   (i),
            .COUNT_W (COUNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .channel    (channel_reg),
            .used_count (used_reg),
            .link_in    (links[i]),
            .link_out   (links[i+1])
        );
    end

    assign tail = links[TABLE_DEPTH];

    // no cell took the request: table full, drop
    always_comb
    begin
        if (tail.done)
        begin
            tail_res = tail.res;
        end
        else
        begin
            tail_res        = '0;
            tail_res.status = slt_pkg::STATUS_DROPPED;
        end
    end

    always_comb
    begin
        launch_next                 = '0;
        launch_next.valid           = accept;
        launch_next.station_address = frame.station_address;
        launch_next.signal_strength = frame.signal_strength;
        launch_next.now_ms          = frame.now_ms;

        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.valid)
        begin
            busy_next = 1'b0;
        end

        used_next = used_reg;
        if (tail.valid && tail.done && (tail.res.status == slt_pkg::STATUS_INSERTED))
        begin
            used_next = used_reg + COUNT_W'(1);
        end

        channel_next = cfg_write ? cfg_data : channel_reg;

        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (tail.valid)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_next       = tail_res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = tail_res;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            used_reg       <= '0;
            channel_reg    <= slt_pkg::CHANNEL_RESET;
            launch_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            used_reg       <= used_next;
            channel_reg    <= channel_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.status        = out_reg.status;
    assign result.entry_index   = out_reg.entry_index;
    assign result.packet_total  = out_reg.packet_total;
    assign result.first_seen_ms = out_reg.first_seen_ms;

    a_tail_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> busy_reg)
        else $error("request left the row with none in flight");

    a_no_skid_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(tail.valid && skid_valid_reg))
        else $error("result arrived while skid stage occupied");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result ahead of the output register");

    a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && !tail.done) |-> (used_reg == FULL))
        else $error("request dropped while table has room");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL)
        else $error("fill count beyond table depth");

endmodule
